FILE: rtl/core/pct_pkg.sv
// ----------------------------------------------------------------------------
// pct_pkg
// types and constants shared by the pending command tracker
// ----------------------------------------------------------------------------
package pct_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int DEFAULT_TICKS_PER_SECOND = 1024;

    localparam int SEQ_W  = 32;
    localparam int WORD_W = 32;
    localparam int TIME_W = 48;
    localparam int AGE_W  = 16;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FIND    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_EXPIRED = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO_SEQ  = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [WORD_W-1:0] flags;
        logic [WORD_W-1:0] contact;
        logic [WORD_W-1:0] ack;
        logic [WORD_W-1:0] dref;
        logic [WORD_W-1:0] size;
        logic [TIME_W-1:0] sent_at;
    } entry_t;

    // command broadcast to every cell
    typedef struct packed {
        logic              add;
        logic              remove;
        logic              clear;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W:0]   now;
        logic [TIME_W:0]   age_ticks;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DONE
    } state_t;

endpackage

FILE: rtl/core/pct_if.sv
// ----------------------------------------------------------------------------
// pct_cmd_if / pct_rsp_if
// valid/ready channels for commands and results
// ----------------------------------------------------------------------------
interface pct_cmd_if;
    import pct_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [SEQ_W-1:0]  seq_num;
    logic [WORD_W-1:0] flags;
    logic [WORD_W-1:0] contact_tag;
    logic [WORD_W-1:0] ack_type;
    logic [WORD_W-1:0] data_ref;
    logic [WORD_W-1:0] data_size;
    logic [TIME_W-1:0] now_time;
    logic [AGE_W-1:0]  age_limit;
    modport source (output valid, command, seq_num, flags, contact_tag, ack_type,
                    data_ref, data_size, now_time, age_limit, input ready);
    modport sink (input valid, command, seq_num, flags, contact_tag, ack_type,
                  data_ref, data_size, now_time, age_limit, output ready);
endinterface

interface pct_rsp_if;
    import pct_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [SEQ_W-1:0]  found_seq_num;
    logic [WORD_W-1:0] found_flags;
    logic [WORD_W-1:0] found_contact;
    logic [WORD_W-1:0] found_ack_type;
    logic [WORD_W-1:0] found_data_ref;
    logic [WORD_W-1:0] found_data_size;
    modport source (output valid, status, found_seq_num, found_flags, found_contact,
                    found_ack_type, found_data_ref, found_data_size, input ready);
    modport sink (input valid, status, found_seq_num, found_flags, found_contact,
                  found_ack_type, found_data_ref, found_data_size, output ready);
endinterface

FILE: rtl/core/pct_cell.sv
// ----------------------------------------------------------------------------
// pct_cell
// one table slot: holds an entry, flags matches, shifts from its upper neighbor
// ----------------------------------------------------------------------------
module pct_cell
    import pct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  logic      eval,
    input  entry_t    new_entry,
    input  logic      up_valid,
    input  entry_t    up_entry,
    input  logic      below_hit,
    input  logic      prev_valid,
    output logic      valid,
    output entry_t    entry,
    output logic      seq_hit,
    output logic      exp_hit,
    output logic      hit_out
);

    logic   valid_reg, valid_next;
    entry_t entry_reg, entry_next;
    logic   seq_hit_reg, exp_hit_reg;
    logic [TIME_W:0] limit;

    assign limit = {1'b0, entry_reg.sent_at} + ctl.age_ticks;

    // match flags registered in the eval cycle, used next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_hit_reg <= 1'b0;
            exp_hit_reg <= 1'b0;
        end
        else if (eval)
        begin
            seq_hit_reg <= valid_reg && (entry_reg.seq == ctl.seq);
            exp_hit_reg <= valid_reg && (limit < ctl.now);
        end
    end

    assign hit_out = below_hit | seq_hit_reg;

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.add)
        begin
            // first empty slot takes the new entry
            if (!valid_reg && prev_valid)
            begin
                valid_next = 1'b1;
                entry_next = new_entry;
            end
        end
        else if (ctl.remove)
        begin
            if (below_hit || seq_hit_reg)
            begin
                valid_next = up_valid;
                entry_next = up_entry;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign valid   = valid_reg;
    assign entry   = entry_reg;
    assign seq_hit = seq_hit_reg;
    assign exp_hit = exp_hit_reg;

endmodule

FILE: rtl/core/pct_chain.sv
// ----------------------------------------------------------------------------
// pct_chain
// row of cells plus first-match selection of a reported entry
// ----------------------------------------------------------------------------
module pct_chain
    import pct_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  logic      eval,
    input  logic      use_expiry,
    input  entry_t    new_entry,
    output logic      full,
    output logic      any_hit,
    output entry_t    hit_entry
);

    logic   valid   [DEPTH];
    entry_t entry   [DEPTH];
    logic   seq_hit [DEPTH];
    logic   exp_hit [DEPTH];
    logic   hit_c   [DEPTH];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic   up_v;
            entry_t up_e;
            logic   below;
            logic   prev_v;
            if (g == DEPTH - 1)
            begin : g_top
                assign up_v = 1'b0;
                assign up_e = entry[g];
            end
            else
            begin : g_mid
                assign up_v = valid[g+1];
                assign up_e = entry[g+1];
            end
            if (g == 0)
            begin : g_bot
                assign below  = 1'b0;
                assign prev_v = 1'b1;
            end
            else
            begin : g_up
                assign below  = hit_c[g-1];
                assign prev_v = valid[g-1];
            end
            pct_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .eval       (eval),
                .new_entry  (new_entry),
                .up_valid   (up_v),
                .up_entry   (up_e),
                .below_hit  (below),
                .prev_valid (prev_v),
                .valid      (valid[g]),
                .entry      (entry[g]),
                .seq_hit    (seq_hit[g]),
                .exp_hit    (exp_hit[g]),
                .hit_out    (hit_c[g])
            );
        end
    endgenerate

    assign full = valid[DEPTH-1];

    // first match from the low end
    always_comb
    begin
        any_hit   = 1'b0;
        hit_entry = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (use_expiry ? exp_hit[i] : seq_hit[i])
            begin
                any_hit   = 1'b1;
                hit_entry = entry[i];
            end
        end
    end

endmodule

FILE: rtl/core/pending_command_tracker.sv
// ----------------------------------------------------------------------------
// pending_command_tracker
// insertion-ordered table of outstanding commands with lookup and timeout
// ----------------------------------------------------------------------------
// a command is registered on transfer; the eval state registers the cell match
//   flags and the done state presents the result; a new command is accepted
//   only after the result is taken. Adds write in eval, removes shift in done
// reset: table empty, no result pending
module pending_command_tracker
    import pct_pkg::*;
#(
    parameter int DEPTH            = DEFAULT_DEPTH,
    parameter int TICKS_PER_SECOND = DEFAULT_TICKS_PER_SECOND
)
(
    input logic        clk,
    input logic        rst_n,
    pct_cmd_if.sink    cmd,
    pct_rsp_if.source  rsp
);

    localparam logic [TIME_W:0] TICKS = (TIME_W+1)'(TICKS_PER_SECOND);

    state_t state_reg, state_next;

    logic [CMD_W-1:0]  cmd_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W:0]   age_ticks_reg;
    entry_t            new_reg;

    logic [STAT_W-1:0] status_reg, status_next;

    cell_ctl_t ctl;
    logic      eval;
    logic      full, any_hit;
    entry_t    hit_entry;
    logic      take;

    assign take = cmd.valid && cmd.ready;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg       <= cmd.command;
            seq_reg       <= cmd.seq_num;
            now_reg       <= cmd.now_time;
            age_ticks_reg <= (TIME_W+1)'(cmd.age_limit) * TICKS;
            new_reg.seq     <= cmd.seq_num;
            new_reg.flags   <= cmd.flags;
            new_reg.contact <= cmd.contact_tag;
            new_reg.ack     <= cmd.ack_type;
            new_reg.dref    <= cmd.data_ref;
            new_reg.size    <= cmd.data_size;
            new_reg.sent_at <= cmd.now_time;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (take) state_next = S_EVAL;
            S_EVAL: state_next = S_DONE;
            S_DONE: if (rsp.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // eval registers matches; add/clear apply into done, remove out of done
    always_comb
    begin
        eval          = (state_reg == S_EVAL);
        ctl.seq       = seq_reg;
        ctl.now       = {1'b0, now_reg};
        ctl.age_ticks = age_ticks_reg;
        ctl.add       = 1'b0;
        ctl.remove    = 1'b0;
        ctl.clear     = 1'b0;
        status_next   = ST_OK;
        if (eval)
        begin
            case (cmd_reg)
                CMD_ADD:
                begin
                    if (seq_reg == '0)
                        status_next = ST_ZERO_SEQ;
                    else if (full)
                        status_next = ST_FULL;
                    else
                        ctl.add = 1'b1;
                end
                CMD_CLEAR: ctl.clear = 1'b1;
                default: ;
            endcase
        end
        else if (state_reg == S_DONE)
        begin
            // match flags are ready now
            case (cmd_reg)
                CMD_REMOVE: ctl.remove = rsp.ready;
                default: ;
            endcase
        end
    end

    pct_chain #(.DEPTH(DEPTH)) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .eval       (eval),
        .use_expiry (cmd_reg == CMD_EXPIRED),
        .new_entry  (new_reg),
        .full       (full),
        .any_hit    (any_hit),
        .hit_entry  (hit_entry)
    );

    always_ff @(posedge clk)
    begin
        if (eval)
            status_reg <= status_next;
    end

    // lookups resolve from the registered match flags in the done state
    always_comb
    begin
        rsp.status          = status_reg;
        rsp.found_seq_num   = '0;
        rsp.found_flags     = '0;
        rsp.found_contact   = '0;
        rsp.found_ack_type  = '0;
        rsp.found_data_ref  = '0;
        rsp.found_data_size = '0;
        case (cmd_reg)
            CMD_REMOVE: rsp.status = any_hit ? ST_OK : ST_NOT_FOUND;
            CMD_FIND, CMD_EXPIRED:
            begin
                rsp.status = any_hit ? ST_OK : ST_NOT_FOUND;
                if (any_hit)
                begin
                    rsp.found_seq_num   = hit_entry.seq;
                    rsp.found_flags     = hit_entry.flags;
                    rsp.found_contact   = hit_entry.contact;
                    rsp.found_ack_type  = hit_entry.ack;
                    rsp.found_data_ref  = hit_entry.dref;
                    rsp.found_data_size = hit_entry.size;
                end
            end
            default: ;
        endcase
    end

    assign rsp.valid = (state_reg == S_DONE);
    assign cmd.ready = (state_reg == S_IDLE);

endmodule

FILE: tb/pct_tb_pkg.sv
// ----------------------------------------------------------------------------
// pct_tb_pkg
// table predictor and result scoreboard for the pending command tracker
// ----------------------------------------------------------------------------
package pct_tb_pkg;

    import pct_pkg::*;

    localparam int TB_DEPTH = DEFAULT_DEPTH;
    localparam int TB_TPS   = DEFAULT_TICKS_PER_SECOND;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SEQ_W-1:0]  seq_num;
        logic [WORD_W-1:0] flags;
        logic [WORD_W-1:0] contact_tag;
        logic [WORD_W-1:0] ack_type;
        logic [WORD_W-1:0] data_ref;
        logic [WORD_W-1:0] data_size;
        logic [TIME_W-1:0] now_time;
        logic [AGE_W-1:0]  age_limit;
    } cmd_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SEQ_W-1:0]  seq;
        logic [WORD_W-1:0] flags;
        logic [WORD_W-1:0] contact;
        logic [WORD_W-1:0] ack;
        logic [WORD_W-1:0] dref;
        logic [WORD_W-1:0] size;
    } result_t;

    class tracker_scoreboard;
        entry_t    table_q[$];
        result_t   pending_results[$];
        int        error_count;

        function automatic void note_command(cmd_item_t c);
            result_t r;
            logic [TIME_W:0] deadline;
            r = '0;
            case (c.command)
                CMD_ADD:
                begin
                    if (c.seq_num == 0)
                        r.status = ST_ZERO_SEQ;
                    else if (table_q.size() >= TB_DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        table_q.push_back({c.seq_num, c.flags, c.contact_tag, c.ack_type,
                                           c.data_ref, c.data_size, c.now_time});
                        r.status = ST_OK;
                    end
                end
                CMD_REMOVE:
                begin
                    r.status = ST_NOT_FOUND;
                    foreach (table_q[i])
                        if (table_q[i].seq == c.seq_num)
                        begin
                            table_q.delete(i);
                            r.status = ST_OK;
                            break;
                        end
                end
                CMD_FIND, CMD_EXPIRED:
                begin
                    r.status = ST_NOT_FOUND;
                    foreach (table_q[i])
                    begin
                        deadline = {1'b0, table_q[i].sent_at}
                                   + ({33'd0, c.age_limit} * TB_TPS);
                        if ((c.command == CMD_FIND && table_q[i].seq == c.seq_num) ||
                            (c.command == CMD_EXPIRED && deadline < {1'b0, c.now_time}))
                        begin
                            r = {ST_OK, table_q[i].seq, table_q[i].flags,
                                 table_q[i].contact, table_q[i].ack,
                                 table_q[i].dref, table_q[i].size};
                            break;
                        end
                    end
                end
                CMD_CLEAR:
                begin
                    table_q.delete();
                    r.status = ST_OK;
                end
                default:
                    r.status = ST_OK;
            endcase
            pending_results.push_back(r);
        endfunction

        task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %h expected %h", what, got, want);
            error_count++;
        endtask

        task automatic check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", 64'(got.status), 64'd0);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", 64'(got.status), 64'(want.status));
            if (got.seq !== want.seq)
                report_mismatch("found_seq_num", 64'(got.seq), 64'(want.seq));
            if (got.flags !== want.flags)
                report_mismatch("found_flags", 64'(got.flags), 64'(want.flags));
            if (got.contact !== want.contact)
                report_mismatch("found_contact", 64'(got.contact), 64'(want.contact));
            if (got.ack !== want.ack)
                report_mismatch("found_ack_type", 64'(got.ack), 64'(want.ack));
            if (got.dref !== want.dref)
                report_mismatch("found_data_ref", 64'(got.dref), 64'(want.dref));
            if (got.size !== want.size)
                report_mismatch("found_data_size", 64'(got.size), 64'(want.size));
        endtask
    endclass

endpackage

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives add/remove/find/expiry/clear and unused opcodes with random gaps and
// stalls, predicting each result from a queue model of the table
// ----------------------------------------------------------------------------
module tb;

    import pct_pkg::*;
    import pct_tb_pkg::*;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_off_cycles;

    tracker_scoreboard tracker;

    pct_cmd_if cmd_ch ();
    pct_rsp_if rsp_ch ();

    pending_command_tracker i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // small pool of numbers so removes and finds hit often
    logic [SEQ_W-1:0] seq_pool [8];
    logic [TIME_W-1:0] clock_ticks;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cmd_ch.valid       = 1'b0;
        cmd_ch.command     = CMD_ADD;
        cmd_ch.seq_num     = '0;
        cmd_ch.flags       = '0;
        cmd_ch.contact_tag = '0;
        cmd_ch.ack_type    = '0;
        cmd_ch.data_ref    = '0;
        cmd_ch.data_size   = '0;
        cmd_ch.now_time    = '0;
        cmd_ch.age_limit   = '0;
        rsp_ch.ready       = 1'b0;
    end

    // valid drops only while the sender idles
    task automatic send_command(cmd_item_t c);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.command     <= c.command;
        cmd_ch.seq_num     <= c.seq_num;
        cmd_ch.flags       <= c.flags;
        cmd_ch.contact_tag <= c.contact_tag;
        cmd_ch.ack_type    <= c.ack_type;
        cmd_ch.data_ref    <= c.data_ref;
        cmd_ch.data_size   <= c.data_size;
        cmd_ch.now_time    <= c.now_time;
        cmd_ch.age_limit   <= c.age_limit;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        tracker.note_command(c);
        @(negedge clk);
    endtask

    function automatic cmd_item_t make_command(logic [CMD_W-1:0] op,
                                               logic [SEQ_W-1:0] seq);
        cmd_item_t c;
        logic [287:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom};
        c = raw[$bits(cmd_item_t)-1:0];
        c.command  = op;
        c.seq_num  = seq;
        c.now_time = clock_ticks;
        c.age_limit = AGE_W'($urandom_range(3));
        return c;
    endfunction

    function automatic cmd_item_t random_command();
        cmd_item_t c;
        int pick;
        logic [SEQ_W-1:0] seq;
        pick = $urandom_range(99);
        seq = ($urandom_range(9) == 0) ? $urandom : seq_pool[$urandom_range(7)];
        if ($urandom_range(49) == 0)
            seq = '0;
        if (pick < 40)
            c = make_command(CMD_ADD, seq);
        else if (pick < 60)
            c = make_command(CMD_REMOVE, seq);
        else if (pick < 78)
            c = make_command(CMD_FIND, seq);
        else if (pick < 94)
            c = make_command(CMD_EXPIRED, seq);
        else if (pick < 97)
            c = make_command(CMD_CLEAR, seq);
        else
            c = make_command(CMD_W'($urandom_range(7, 5)), seq);
        if ($urandom_range(19) == 0)
            c.age_limit = AGE_W'($urandom);
        return c;
    endfunction

    task automatic run_phase(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
        begin
            clock_ticks = clock_ticks + TIME_W'($urandom_range(4000));
            send_command(random_command());
        end
    endtask

    // result side: sample at posedge, change ready at negedge
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_off_cycles--;
            end
            else
                rsp_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            tracker.check_result({rsp_ch.status, rsp_ch.found_seq_num,
                                  rsp_ch.found_flags, rsp_ch.found_contact,
                                  rsp_ch.found_ack_type, rsp_ch.found_data_ref,
                                  rsp_ch.found_data_size});
    end

    initial
    begin
        #5000000;
        $display("pending_command_tracker test failed");
        $finish;
    end

    initial
    begin
        cmd_item_t c;
        int wait_cycles;
        tracker = new();
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        clock_ticks     = 48'd100000;
        foreach (seq_pool[i])
            seq_pool[i] = (i == 0) ? 32'hFFFF_FFFF : $urandom | 32'd1;
        rst_n = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: zero number, lookups on empty table, all-ones fields
        send_command(make_command(CMD_ADD, '0));
        send_command(make_command(CMD_FIND, seq_pool[0]));
        send_command(make_command(CMD_EXPIRED, '0));
        send_command(make_command(CMD_REMOVE, '0));
        c = '1;
        c.command = CMD_ADD;
        c.now_time = '0;
        send_command(c);
        c = '1;
        c.command = CMD_FIND;
        send_command(c);
        // expiry with maximal age and time: sum must not wrap
        c = '1;
        c.command = CMD_EXPIRED;
        send_command(c);
        c.age_limit = '0;
        send_command(c);
        // fill past capacity
        for (int i = 1; i <= TB_DEPTH; i++)
            send_command(make_command(CMD_ADD, SEQ_W'(i)));
        send_command(make_command(CMD_REMOVE, 32'd3));
        send_command(make_command(CMD_FIND, 32'd4));
        send_command(make_command(CMD_FIND, '0));
        send_command(make_command(CMD_W'(5), 32'd1));
        send_command(make_command(CMD_W'(7), 32'd1));
        send_command(make_command(CMD_CLEAR, '0));

        run_phase(100, 0, 0);
        run_phase(80, 79, 0);
        run_phase(80, 0, 79);
        run_phase(80, 32, 32);
        // long receiver hold-off while adds keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 200;
        for (int i = 0; i < 20; i++)
            send_command(make_command(CMD_ADD, seq_pool[i % 8]));
        run_phase(60, 0, 0);
        cmd_ch.valid <= 1'b0;

        wait_cycles = 0;
        while (tracker.pending_results.size() != 0 && wait_cycles < 10000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (10) @(posedge clk);
        if (tracker.error_count == 0 && tracker.pending_results.size() == 0)
            $display("pending_command_tracker test passed");
        else
            $display("pending_command_tracker test failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/pct_pkg.sv
rtl/core/pct_if.sv
rtl/core/pct_cell.sv
rtl/core/pct_chain.sv
rtl/core/pending_command_tracker.sv
tb/pct_tb_pkg.sv
tb/tb.sv
